@@ src/pugs_pkg.sv @@
// Shared types and constants for the pooled unit grant scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pugs_pkg;

	// default configuration
	localparam int UNITS_DEF       = 5;
	localparam int QUEUE_DEPTH_DEF = 3;

	// item kinds
	localparam logic KIND_REQ = 1'b0;
	localparam logic KIND_REL = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_QFULL    = 2'd1,
		STAT_BAD_IDX  = 2'd2,
		STAT_FREE_REL = 2'd3
	} status_t;

	// input item
	typedef struct packed {
		logic       kind;
		logic [7:0] requester_id;
		logic [2:0] unit_count;
		logic [2:0] released_unit;
	} in_item_t;

	// result item
	typedef struct packed {
		logic       granted;
		logic [2:0] unit_index;
		logic [7:0] grantee_id;
		status_t    status;
		logic [2:0] units_free;
		logic       last;
	} out_item_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_GRANT,
		S_FINISH
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // take the accepted item
		logic take;      // current queue entry is chosen
		logic keep;      // current queue entry stays, compact it
		logic commit;    // write back the compacted fill level
		logic grant;     // grant one unit to the chosen entry
		logic finish;    // emit the closing result
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_end;    // scan index reached fill level
		logic head_fail;   // head entry does not fit
		logic fits;        // current entry fits in free units
		logic cnt_zero;    // current entry asks for no units
		logic grant_last;  // last unit of the chosen entry
		logic hold_valid;  // a grant result is held back
		logic out_free;    // output register can take a result
	} dp_sts_t;

endpackage

@@ src/pugs_ctrl.sv @@
// Controller state machine for the pooled unit grant scheduler.
// Depends on pugs_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module pugs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  pugs_pkg::dp_sts_t sts,
	output pugs_pkg::dp_cmd_t ctl
);
	import pugs_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				priority if (sts.scan_end) state_d = S_FINISH;
				else if (sts.head_fail) state_d = S_FINISH;
				else if (sts.fits && !sts.cnt_zero) state_d = S_GRANT;
				else state_d = S_SCAN;
			end
			S_GRANT: begin
				if ((!sts.hold_valid || sts.out_free) && sts.grant_last) state_d = S_SCAN;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				ctl.load  = cmd_valid;
			end
			S_SCAN: begin
				priority if (sts.scan_end) ctl.commit = 1'b1;
				else if (sts.head_fail) ctl = '0;
				else if (sts.fits) ctl.take = 1'b1;
				else ctl.keep = 1'b1;
			end
			S_GRANT: begin
				ctl.grant = !sts.hold_valid || sts.out_free;
			end
			S_FINISH: begin
				ctl.finish = sts.out_free;
			end
			default: ctl = '0;
		endcase
	end

endmodule

@@ src/pugs_dp.sv @@
// Datapath for the pooled unit grant scheduler: busy map, request queue,
// grant hold stage and output register. Depends on pugs_pkg.
`timescale 1ns / 1ps

module pugs_dp #(
	parameter int UNITS       = pugs_pkg::UNITS_DEF,
	parameter int QUEUE_DEPTH = pugs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pugs_pkg::in_item_t  cmd,
	input  pugs_pkg::dp_cmd_t   ctl,
	output pugs_pkg::dp_sts_t   sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pugs_pkg::out_item_t rsp
);
	import pugs_pkg::*;

	localparam int IDX_W  = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int CNT_W  = $clog2(UNITS + 1);
	localparam int CMP_W  = (CNT_W > 3) ? CNT_W : 3;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// control state
	logic [UNITS-1:0]  busy_q;
	logic [CNT_W-1:0]  free_q;
	logic [QCNT_W-1:0] fill_q;
	logic [QCNT_W-1:0] rd_q;
	logic [QCNT_W-1:0] wr_q;
	logic              hold_v_q;
	logic              out_v_q;

	// payload state
	logic [2:0]        q_cnt_q [QUEUE_DEPTH];
	logic [7:0]        q_id_q  [QUEUE_DEPTH];
	logic [2:0]        left_q;
	logic [7:0]        gid_q;
	status_t           status_q;
	out_item_t         hold_q;
	out_item_t         out_q;

	logic [2:0]        cur_cnt;
	logic [7:0]        cur_id;
	logic              fits;
	logic [IDX_W-1:0]  low_u;
	logic              rel_bad;
	logic              rel_busy;
	logic              q_full;
	logic              out_free;
	status_t           status_d;

	// current queue entry
	assign cur_cnt = q_cnt_q[rd_q[QPTR_W-1:0]];
	assign cur_id  = q_id_q[rd_q[QPTR_W-1:0]];
	assign fits    = CMP_W'(cur_cnt) <= CMP_W'(free_q);

	// lowest free unit
	always_comb begin
		low_u = '0;
		for (int k = UNITS - 1; k >= 0; k--) begin
			if (!busy_q[k]) low_u = IDX_W'(k);
		end
	end

	// item checks
	assign rel_bad  = {3'b000, cmd.released_unit} >= 6'(UNITS);
	assign rel_busy = busy_q[0 +: UNITS] >> cmd.released_unit != '0
		&& ((busy_q >> cmd.released_unit) & UNITS'(1)) != '0;
	assign q_full   = fill_q >= QCNT_W'(QUEUE_DEPTH);

	always_comb begin
		status_d = STAT_OK;
		if (cmd.kind == KIND_REQ) begin
			if (q_full) status_d = STAT_QFULL;
		end else begin
			priority if (rel_bad) status_d = STAT_BAD_IDX;
			else if (!rel_busy) status_d = STAT_FREE_REL;
			else status_d = STAT_OK;
		end
	end

	assign out_free = !out_v_q || !rsp_stall;

	// status to controller
	assign sts.scan_end   = rd_q == fill_q;
	assign sts.head_fail  = (rd_q == '0) && !fits;
	assign sts.fits       = fits;
	assign sts.cnt_zero   = cur_cnt == 3'd0;
	assign sts.grant_last = left_q == 3'd1;
	assign sts.hold_valid = hold_v_q;
	assign sts.out_free   = out_free;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			free_q   <= CNT_W'(UNITS);
			fill_q   <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				rd_q     <= '0;
				wr_q     <= '0;
				hold_v_q <= 1'b0;
				if (cmd.kind == KIND_REQ) begin
					if (!q_full) fill_q <= fill_q + QCNT_W'(1);
				end else if (status_d == STAT_OK) begin
					busy_q <= busy_q & ~(UNITS'(1) << cmd.released_unit);
					free_q <= free_q + CNT_W'(1);
				end
			end
			if (ctl.take) rd_q <= rd_q + QCNT_W'(1);
			if (ctl.keep) begin
				rd_q <= rd_q + QCNT_W'(1);
				wr_q <= wr_q + QCNT_W'(1);
			end
			if (ctl.commit) fill_q <= wr_q;
			if (ctl.grant) begin
				busy_q[low_u] <= 1'b1;
				free_q        <= free_q - CNT_W'(1);
				hold_v_q      <= 1'b1;
			end
			if (ctl.finish) hold_v_q <= 1'b0;
			// output register: loaded by a pushed result, emptied when taken
			if ((ctl.grant && hold_v_q) || ctl.finish) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status_q <= status_d;
			if (cmd.kind == KIND_REQ && !q_full) begin
				q_cnt_q[fill_q[QPTR_W-1:0]] <= cmd.unit_count;
				q_id_q[fill_q[QPTR_W-1:0]]  <= cmd.requester_id;
			end
		end
		if (ctl.take) begin
			left_q <= cur_cnt;
			gid_q  <= cur_id;
		end
		if (ctl.keep) begin
			q_cnt_q[wr_q[QPTR_W-1:0]] <= cur_cnt;
			q_id_q[wr_q[QPTR_W-1:0]]  <= cur_id;
		end
		if (ctl.grant) begin
			left_q            <= left_q - 3'd1;
			hold_q.granted    <= 1'b1;
			hold_q.unit_index <= 3'(low_u);
			hold_q.grantee_id <= gid_q;
			hold_q.status     <= status_q;
			hold_q.units_free <= 3'(free_q - CNT_W'(1));
			hold_q.last       <= 1'b0;
			if (hold_v_q) out_q <= hold_q;
		end
		if (ctl.finish) begin
			if (hold_v_q) begin
				out_q.granted    <= hold_q.granted;
				out_q.unit_index <= hold_q.unit_index;
				out_q.grantee_id <= hold_q.grantee_id;
				out_q.status     <= hold_q.status;
				out_q.units_free <= hold_q.units_free;
				out_q.last       <= 1'b1;
			end else begin
				out_q.granted    <= 1'b0;
				out_q.unit_index <= 3'd0;
				out_q.grantee_id <= 8'd0;
				out_q.status     <= status_q;
				out_q.units_free <= 3'(free_q);
				out_q.last       <= 1'b1;
			end
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// free count tracks the busy map
	a_free_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(busy_q) + int'(free_q) == UNITS)
		else $error("free count out of step with busy map");

	// a grant always finds a free unit
	a_grant_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.grant |-> free_q != '0)
		else $error("grant with no free unit");

	// queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	// a pushed result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && rsp_stall) |-> !((ctl.grant && hold_v_q) || ctl.finish))
		else $error("output register overwritten");

endmodule

@@ src/pooled_unit_grant_scheduler_unit.sv @@
// Top level of the pooled unit grant scheduler.
// Depends on pugs_pkg, pugs_ctrl and pugs_dp.
`timescale 1ns / 1ps

// The block keeps a busy map over UNITS identical units and a queue of up to
// QUEUE_DEPTH pending requests. Each item is a request (queued, or rejected
// with status 1 when the queue is full) or the release of one unit (status 2
// for an index at or above UNITS, status 3 for a unit already free). After
// each item, if the head request fits in the free units, the queue is scanned
// in order and every request that still fits is granted the lowest free
// units, one result per unit; the chosen requests leave the queue. Every item
// gives at least one result and the final one carries last. Items are taken
// one at a time: an item occupies the block for its acceptance, one scan
// step per queue entry visited by the scan, one more when the scan runs to
// the end of the queue, one grant per unit granted and the closing result.
// The scan sequencer visits one queue entry or issues one grant per cycle,
// a grant waiting while a held result cannot pass to a stalled output. A
// result waiting on a stalled output stretches the occupancy further.
module pooled_unit_grant_scheduler_unit #(
	parameter int UNITS       = pugs_pkg::UNITS_DEF,
	parameter int QUEUE_DEPTH = pugs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  pugs_pkg::in_item_t  cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pugs_pkg::out_item_t rsp
);
	import pugs_pkg::*;

	dp_cmd_t ctl;
	dp_sts_t sts;

	// sequencer
	pugs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// busy map, queue and result registers
	pugs_dp #(
		.UNITS       (UNITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
